### rtl/sha1sh_pkg.sv
// sha1sh_pkg: shared types and constants of the sha-1 stream hasher
// no dependencies; imported by sha1sh_round, sha1sh_sched and sha1_stream_hasher
`default_nettype none

package sha1sh_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned BlockW   = 512;
  localparam int unsigned Rounds   = 80;
  localparam int unsigned RoundW   = 7;
  localparam int unsigned CountW   = 61;
  localparam int unsigned FillW    = 6;
  localparam int unsigned Words    = 5;
  localparam int unsigned WordIdxW = 3;

  localparam logic [WordW-1:0] K0 = 32'h5A827999;
  localparam logic [WordW-1:0] K1 = 32'h6ED9EBA1;
  localparam logic [WordW-1:0] K2 = 32'h8F1BBCDC;
  localparam logic [WordW-1:0] K3 = 32'hCA62C1D6;

  localparam logic [Words-1:0][WordW-1:0] ChainInit = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam logic [7:0] PadMark = 8'h80;
  localparam logic [FillW-1:0] LenFill = 6'd56;

  localparam logic [0:0] KindData   = 1'b0;
  localparam logic [0:0] KindFinish = 1'b1;

  typedef struct packed {
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    logic [WordW-1:0] c;
    logic [WordW-1:0] d;
    logic [WordW-1:0] e;
  } sha1sh_work_t;

endpackage

`default_nettype wire

### rtl/sha1sh_round.sv
// sha1sh_round: one sha-1 round, shared over all 80 rounds of a block
// depends on sha1sh_pkg
`default_nettype none

module sha1sh_round
  import sha1sh_pkg::*;
(
  input  sha1sh_work_t      work_i,
  input  logic [WordW-1:0]  w_i,
  input  logic [RoundW-1:0] round_i,
  output sha1sh_work_t      work_o
);

  logic [WordW-1:0] f;
  logic [WordW-1:0] k;
  logic [WordW-1:0] t;

  always_comb begin
    priority if (round_i < RoundW'(20)) begin
      f = (work_i.b & work_i.c) | (~work_i.b & work_i.d);
      k = K0;
    end else if (round_i < RoundW'(40)) begin
      f = work_i.b ^ work_i.c ^ work_i.d;
      k = K1;
    end else if (round_i < RoundW'(60)) begin
      f = (work_i.b & work_i.c) | (work_i.b & work_i.d) | (work_i.c & work_i.d);
      k = K2;
    end else begin
      f = work_i.b ^ work_i.c ^ work_i.d;
      k = K3;
    end
  end

  assign t = {work_i.a[26:0], work_i.a[31:27]} + f + work_i.e + k + w_i;

  assign work_o.a = t;
  assign work_o.b = work_i.a;
  assign work_o.c = {work_i.b[1:0], work_i.b[31:2]};
  assign work_o.d = work_i.c;
  assign work_o.e = work_i.d;

endmodule

`default_nettype wire

### rtl/sha1sh_sched.sv
// sha1sh_sched: block buffer that takes bytes and then runs the message schedule
// depends on sha1sh_pkg
`default_nettype none

module sha1sh_sched
  import sha1sh_pkg::*;
(
  input  logic             clk_i,
  input  logic             byte_push_i,
  input  logic [7:0]       byte_i,
  input  logic             word_shift_i,
  output logic [WordW-1:0] w0_o
);

  logic [BlockW-1:0] block_q;
  logic [BlockW-1:0] block_d;
  logic [WordW-1:0]  mix;
  logic [WordW-1:0]  w_next;

  // taps w[13], w[8], w[2], w[0] of the sixteen-word window
  assign mix = block_q[BlockW-1-13*WordW -: WordW] ^ block_q[BlockW-1-8*WordW -: WordW]
             ^ block_q[BlockW-1-2*WordW -: WordW] ^ block_q[BlockW-1 -: WordW];
  assign w_next = {mix[30:0], mix[31]};
  assign w0_o = block_q[BlockW-1 -: WordW];

  always_comb begin
    block_d = block_q;
    if (byte_push_i) begin
      block_d = {block_q[BlockW-9:0], byte_i};
    end else if (word_shift_i) begin
      block_d = {block_q[BlockW-WordW-1:0], w_next};
    end
  end

  always_ff @(posedge clk_i) begin
    block_q <= block_d;
  end

endmodule

`default_nettype wire

### rtl/sha1_stream_hasher.sv
// sha1_stream_hasher: top level, sequencer, chaining words and length count
// depends on sha1sh_pkg, sha1sh_round and sha1sh_sched
`default_nettype none

// Data bytes are taken one per cycle while tready is high. The byte that completes
// a 64-byte block starts a compression: the 80 rounds run one per cycle through a
// single round unit and a final state adds the result into the chaining words, so
// tready is low after that byte until the add is done. A finish request pads the
// block at one byte a cycle, pausing for the compression of each of one or two
// blocks, then presents the five digest words, one per accepted output request, and
// returns to the initial chaining values.
module sha1_stream_hasher
  import sha1sh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic        s_axis_tuser,  // [0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // [31:0] digest_word, [34:32] word_index, rest zero
  output logic        m_axis_tlast   // last_word
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StPad   = 3'd1;
  localparam logic [2:0] StRound = 3'd2;
  localparam logic [2:0] StFinal = 3'd3;
  localparam logic [2:0] StOut   = 3'd4;

  logic [2:0] state_q, state_d;
  logic [Words-1:0][WordW-1:0] chain_q, chain_d;
  sha1sh_work_t work_q, work_d, work_next;
  logic [RoundW-1:0] round_q, round_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [CountW-1:0] count_q, count_d;
  logic finishing_q, finishing_d;
  logic mark_done_q, mark_done_d;
  logic [3:0] len_idx_q, len_idx_d;
  logic [WordIdxW-1:0] out_idx_q, out_idx_d;

  logic in_fire, out_fire;
  logic push_valid;
  logic [7:0] push_byte;
  logic [63:0] len_bits;
  logic [2:0] len_sel;
  logic [7:0] len_byte;
  logic [WordW-1:0] w0;
  logic round_run;

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = (state_q == StOut);
  assign in_fire  = s_axis_tvalid & s_axis_tready;
  assign out_fire = m_axis_tvalid & m_axis_tready;
  assign round_run = (state_q == StRound);

  assign m_axis_tdata = {5'd0, out_idx_q, chain_q[out_idx_q]};
  assign m_axis_tlast = (out_idx_q == WordIdxW'(Words - 1));

  // length bytes go out most significant first
  assign len_bits = {count_q, 3'b000};
  assign len_sel  = 3'(3'd7 - len_idx_q[2:0]);
  assign len_byte = len_bits[{len_sel, 3'b000} +: 8];

  sha1sh_sched u_sched (
    .clk_i        (clk_i),
    .byte_push_i  (push_valid),
    .byte_i       (push_byte),
    .word_shift_i (round_run),
    .w0_o         (w0)
  );

  sha1sh_round u_round (
    .work_i  (work_q),
    .w_i     (w0),
    .round_i (round_q),
    .work_o  (work_next)
  );

  always_comb begin
    push_valid = 1'b0;
    push_byte  = 8'd0;
    if (state_q == StIdle && in_fire && s_axis_tuser == KindData) begin
      push_valid = 1'b1;
      push_byte  = s_axis_tdata;
    end else if (state_q == StPad) begin
      push_valid = 1'b1;
      priority if (!mark_done_q) begin
        push_byte = PadMark;
      end else if (len_idx_q == 4'd0 && fill_q != LenFill) begin
        push_byte = 8'd0;
      end else begin
        push_byte = len_byte;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    chain_d     = chain_q;
    work_d      = work_q;
    round_d     = round_q;
    fill_d      = fill_q;
    count_d     = count_q;
    finishing_d = finishing_q;
    mark_done_d = mark_done_q;
    len_idx_d   = len_idx_q;
    out_idx_d   = out_idx_q;

    if (push_valid) begin
      fill_d = fill_q + FillW'(1);
      if (fill_q == '1) begin
        state_d = StRound;
        round_d = '0;
        work_d  = '{a: chain_q[0], b: chain_q[1], c: chain_q[2], d: chain_q[3],
                    e: chain_q[4]};
      end
    end

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          if (s_axis_tuser == KindData) begin
            count_d = count_q + CountW'(1);
          end else begin
            state_d     = StPad;
            finishing_d = 1'b1;
            mark_done_d = 1'b0;
            len_idx_d   = 4'd0;
          end
        end
      end
      StPad: begin
        if (!mark_done_q) begin
          mark_done_d = 1'b1;
        end else if (len_idx_q != 4'd0 || fill_q == LenFill) begin
          len_idx_d = len_idx_q + 4'd1;
        end
      end
      StRound: begin
        work_d  = work_next;
        round_d = round_q + RoundW'(1);
        if (round_q == RoundW'(Rounds - 1)) begin
          state_d = StFinal;
        end
      end
      StFinal: begin
        chain_d[0] = chain_q[0] + work_q.a;
        chain_d[1] = chain_q[1] + work_q.b;
        chain_d[2] = chain_q[2] + work_q.c;
        chain_d[3] = chain_q[3] + work_q.d;
        chain_d[4] = chain_q[4] + work_q.e;
        priority if (!finishing_q) begin
          state_d = StIdle;
        end else if (len_idx_q == 4'd8) begin
          state_d   = StOut;
          out_idx_d = '0;
        end else begin
          state_d = StPad;
        end
      end
      StOut: begin
        if (out_fire) begin
          out_idx_d = out_idx_q + WordIdxW'(1);
          if (m_axis_tlast) begin
            state_d     = StIdle;
            chain_d     = ChainInit;
            count_d     = '0;
            fill_d      = '0;
            finishing_d = 1'b0;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      chain_q     <= ChainInit;
      round_q     <= '0;
      fill_q      <= '0;
      count_q     <= '0;
      finishing_q <= 1'b0;
      mark_done_q <= 1'b0;
      len_idx_q   <= '0;
      out_idx_q   <= '0;
    end else begin
      state_q     <= state_d;
      chain_q     <= chain_d;
      round_q     <= round_d;
      fill_q      <= fill_d;
      count_q     <= count_d;
      finishing_q <= finishing_d;
      mark_done_q <= mark_done_d;
      len_idx_q   <= len_idx_d;
      out_idx_q   <= out_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
  end

`ifndef NO_ASSERTIONS
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input and output sides active together");

  a_round_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRound) |-> (fill_q == '0 && round_q < RoundW'(Rounds)))
    else $error("compression running on a partial block");

  a_out_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StOut) |-> (len_idx_q == 4'd8 && finishing_q && fill_q == '0))
    else $error("digest presented before padding finished");

  a_reinit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && m_axis_tlast) |=> (chain_q == ChainInit && count_q == '0))
    else $error("state not restored after digest");
`endif

endmodule

`default_nettype wire

### sim/sha1_stream_hasher_test.sv
// sha1_stream_hasher_test: self-checking bench for the sha-1 stream hasher
// streams random byte messages and finish requests, checks every digest word against
// a behavioural sha-1 kept in a scoreboard class; needs sha1sh_pkg and the rtl
`timescale 1ns / 1ps

module sha1_stream_hasher_test
  import sha1sh_pkg::*;
;

  localparam int unsigned TargetItems = 500;
  localparam int unsigned HoldAt      = 40;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned IdleLimit   = 5000;
  localparam int unsigned DrainCycles = 300;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_part_t;

  class sha1_scoreboard;
    logic [31:0]  chain [5];
    logic [31:0]  block [16];
    int unsigned  fill;
    logic [60:0]  byte_count;
    digest_part_t digest_q [$];
    int unsigned  mismatches;
    int unsigned  words_checked;
    int unsigned  digests;

    function new();
      mismatches    = 0;
      words_checked = 0;
      digests       = 0;
      restart();
    endfunction

    function void restart();
      chain[0] = 32'h67452301;
      chain[1] = 32'hEFCDAB89;
      chain[2] = 32'h98BADCFE;
      chain[3] = 32'h10325476;
      chain[4] = 32'hC3D2E1F0;
      foreach (block[i]) block[i] = '0;
      fill       = 0;
      byte_count = '0;
    endfunction

    function logic [31:0] rotl(logic [31:0] x, int unsigned n);
      return (x << n) | (x >> (32 - n));
    endfunction

    function void compress();
      logic [31:0] w [80];
      logic [31:0] a, b, c, d, e, f, k, t;
      for (int i = 0; i < 16; i++) w[i] = block[i];
      for (int i = 16; i < 80; i++) w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      e = chain[4];
      for (int i = 0; i < 80; i++) begin
        if (i < 20) begin
          f = (b & c) | (~b & d);
          k = 32'h5A827999;
        end else if (i < 40) begin
          f = b ^ c ^ d;
          k = 32'h6ED9EBA1;
        end else if (i < 60) begin
          f = (b & c) | (b & d) | (c & d);
          k = 32'h8F1BBCDC;
        end else begin
          f = b ^ c ^ d;
          k = 32'hCA62C1D6;
        end
        t = rotl(a, 5) + f + e + k + w[i];
        e = d;
        d = c;
        c = rotl(b, 30);
        b = a;
        a = t;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
      chain[4] += e;
    endfunction

    function void absorb(logic [7:0] value);
      block[fill / 4][8 * (3 - fill % 4) +: 8] = value;
      fill++;
      if (fill == 64) begin
        compress();
        fill = 0;
      end
    endfunction

    function void note_request(logic kind, logic [7:0] value);
      logic [63:0]  bit_len;
      digest_part_t part;
      if (kind == KindData) begin
        byte_count++;
        absorb(value);
      end else begin
        bit_len = {byte_count, 3'b000};
        absorb(8'h80);
        while (fill != 56) absorb(8'h00);
        for (int i = 0; i < 8; i++) absorb(bit_len[63 - 8 * i -: 8]);
        for (int i = 0; i < 5; i++) begin
          part.word  = chain[i];
          part.index = 3'(i);
          part.last  = (i == 4);
          digest_q.push_back(part);
        end
        digests++;
        restart();
      end
    endfunction

    function void check_result(logic [39:0] tdata, logic tlast);
      digest_part_t want;
      words_checked++;
      if (digest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected digest word %h last %b", tdata, tlast);
        return;
      end
      want = digest_q.pop_front();
      if (tdata[31:0] !== want.word || tdata[34:32] !== want.index ||
          tdata[39:35] !== 5'd0 || tlast !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"digest mismatch: expected word %h index %0d last %b, ",
                    "got %h index %0d last %b pad %b"},
                   want.word, want.index, want.last, tdata[31:0], tdata[34:32], tlast,
                   tdata[39:35]);
      end
    endfunction

    function int unsigned pending();
      return digest_q.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;

  sha1_scoreboard sb = new();
  int unsigned    requests_sent = 0;
  int unsigned    messages_sent = 0;
  int unsigned    gap_pct = 0;
  int unsigned    stall_pct = 0;
  int unsigned    idle_cycles = 0;

  always #5 clk_i = ~clk_i;

  sha1_stream_hasher dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // accepted requests feed the hash, accepted digest words are checked
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_request(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tlast);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("watchdog: no transfer for %0d cycles", idle_cycles);
          $display("[sha1_stream_hasher] ERROR");
          $finish;
        end
      end
    end
  end

  // digest side: random back-pressure plus one long hold-off
  initial begin
    bit held;
    held = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!held && requests_sent >= HoldAt) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        held = 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
        @(posedge clk_i);
      end
    end
  end

  task automatic send_request(input logic kind, input logic [7:0] value);
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= value;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    requests_sent++;
  endtask

  task automatic send_message(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_request(KindData, 8'($urandom_range(255)));
    send_request(KindFinish, 8'($urandom_range(255)));
    messages_sent++;
  endtask

  task automatic set_phase();
    case ((requests_sent * 4) / TargetItems)
      0: begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      1: begin
        gap_pct   = 61;
        stall_pct = 0;
      end
      2: begin
        gap_pct   = 0;
        stall_pct = 61;
      end
      default: begin
        gap_pct   = 6;
        stall_pct = 6;
      end
    endcase
  endtask

  initial begin
    int unsigned edge_lens [10];
    int unsigned len;
    int unsigned pick;
    edge_lens = '{0, 1, 55, 56, 57, 63, 64, 65, 119, 120};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty message, "abc", a four-byte message of 00, FF, 5A and A5, then empty again
    send_request(KindFinish, 8'h00);
    send_request(KindData, 8'h61);
    send_request(KindData, 8'h62);
    send_request(KindData, 8'h63);
    send_request(KindFinish, 8'hFF);
    send_request(KindData, 8'h00);
    send_request(KindData, 8'hFF);
    send_request(KindData, 8'h5A);
    send_request(KindData, 8'hA5);
    send_request(KindFinish, 8'h00);
    send_request(KindFinish, 8'h00);
    messages_sent += 4;

    while (requests_sent < TargetItems || sb.digests < 12) begin
      set_phase();
      pick = $urandom_range(9);
      if (pick < 3) len = edge_lens[$urandom_range(9)];
      else if (pick == 3) len = $urandom_range(200, 65);
      else len = $urandom_range(54, 1);
      send_message(len);
    end
    s_axis_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("%0d requests in %0d messages, block-boundary lengths and back-pressure phases",
             requests_sent, messages_sent);
    $display("%0d digests, %0d words checked, %0d mismatches",
             sb.digests, sb.words_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[sha1_stream_hasher] OK");
    end else begin
      $display("[sha1_stream_hasher] ERROR");
    end
    $finish;
  end

endmodule

### sim.f
rtl/sha1sh_pkg.sv
rtl/sha1sh_round.sv
rtl/sha1sh_sched.sv
rtl/sha1_stream_hasher.sv
sim/sha1_stream_hasher_test.sv
